[src/ptle_pkg.sv]
package ptle_pkg;

  localparam int unsigned TIMER_SLOTS_DEF = 16;

  localparam int unsigned ID_W    = 5;
  localparam int unsigned OWN_W   = 8;
  localparam int unsigned PER_W   = 35;
  localparam int unsigned DL_W    = 48;
  localparam int unsigned MS_W    = 24;
  localparam int unsigned TID_W   = 8;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned OP_W    = 3;
  // candidate id reaches at most TIMER_SLOTS
  localparam int unsigned CAND_W  = 7;
  localparam int unsigned USED_W  = 1 << ID_W;

  localparam logic [9:0]      US_PER_MS = 10'd1000;
  localparam logic [DL_W-1:0] DL_MAX    = {DL_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 3'd0,
    OP_DEL_ID  = 3'd1,
    OP_DEL_OWN = 3'd2,
    OP_DEL_ALL = 3'd3,
    OP_TICK    = 3'd4
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    K_ADD  = 2'd0,
    K_DEL  = 2'd1,
    K_FIRE = 2'd2,
    K_SUM  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_NOP = 3'd0,
    ST_WDL = 3'd1,
    ST_INS = 3'd2,
    ST_DEL = 3'd3,
    ST_CLR = 3'd4
  } st_op_e;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [OWN_W-1:0] own;
    logic [PER_W-1:0] per;
    logic [DL_W-1:0]  dl;
  } entry_t;

  typedef struct packed {
    st_op_e op;
    entry_t ent;
  } st_cmd_t;

endpackage

[src/periodic_timer_list_engine.sv]
// Ordered list of up to TIMER_SLOTS periodic timers. One operation word is
// taken at a time; in_stall_o stays high until its last result word is
// loaded into the output register. A shared 48-bit saturating adder and
// comparator visit one list entry per cycle in the add and delete scans;
// add then searches the lowest free id and inserts, delete all clears the
// list, and tick checks and rewrites each due timer, waiting while the
// output is stalled. Unknown opcodes are dropped without a result.
module periodic_timer_list_engine #(
  parameter int unsigned TIMER_SLOTS = ptle_pkg::TIMER_SLOTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ptle_pkg::OP_W-1:0]    opcode_i,
  input  logic [ptle_pkg::DL_W-1:0]    now_us_i,
  input  logic [ptle_pkg::MS_W-1:0]    interval_ms_i,
  input  logic [ptle_pkg::TID_W-1:0]   timer_id_i,
  input  logic [ptle_pkg::OWN_W-1:0]   owner_tag_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ptle_pkg::KIND_W-1:0]  kind_o,
  output logic [ptle_pkg::ID_W-1:0]    result_id_o,
  output logic [ptle_pkg::OWN_W-1:0]   fired_owner_o,
  output logic                         success_o,
  output logic [ptle_pkg::CNT_W-1:0]   active_count_o,
  output logic                         last_o
);
  import ptle_pkg::*;

  localparam int unsigned IXW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned CW  = $clog2(TIMER_SLOTS + 1);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_ADD_MUL  = 11'b00000000010,
    S_ADD_DL   = 11'b00000000100,
    S_ADD_SCAN = 11'b00000001000,
    S_ADD_ID   = 11'b00000010000,
    S_ADD_INS  = 11'b00000100000,
    S_DEL_ID   = 11'b00001000000,
    S_DEL_OWN  = 11'b00010000000,
    S_TK_CHK   = 11'b00100000000,
    S_TK_FIX   = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       pos_q, pos_d;
  logic                pos_found_q, pos_found_d;
  logic [USED_W-1:0]   used_q, used_d;
  logic [CAND_W-1:0]   cand_q, cand_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [KIND_W-1:0]   res_kind_q, res_kind_d;
  logic [ID_W-1:0]     res_id_q, res_id_d;
  logic                res_ok_q, res_ok_d;

  logic [DL_W-1:0]     now_q;
  logic [MS_W-1:0]     ms_q;
  logic [TID_W-1:0]    tid_q;
  logic [OWN_W-1:0]    own_q;
  logic [PER_W-1:0]    per_q, per_d;
  logic [DL_W-1:0]     newdl_q, newdl_d;
  logic [DL_W-1:0]     sum_q, sum_d;

  logic                out_valid_q;
  logic [KIND_W-1:0]   out_kind_q, o_kind;
  logic [ID_W-1:0]     out_id_q, o_id;
  logic [OWN_W-1:0]    out_own_q, o_own;
  logic                out_ok_q, o_ok;
  logic [CNT_W-1:0]    out_cnt_q, o_cnt;
  logic                out_last_q, o_last;
  logic                out_load;

  st_cmd_t             cmd;
  logic [IXW-1:0]      cmd_idx;
  entry_t              rd_ent;
  logic [CW-1:0]       count;
  logic [DL_W-1:0]     add_a, cmp_a, cmp_b, sum;
  logic [PER_W-1:0]    add_b;
  logic                lt;
  logic                in_acc, emit, scan_end;

  ptle_alu u_alu (
    .add_a_i (add_a),
    .add_b_i (add_b),
    .cmp_a_i (cmp_a),
    .cmp_b_i (cmp_b),
    .sum_o   (sum),
    .lt_o    (lt)
  );

  ptle_store #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .IXW         (IXW),
    .CW          (CW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .cmd_idx_i (cmd_idx),
    .rd_idx_i  (idx_q[IXW-1:0]),
    .rd_ent_o  (rd_ent),
    .count_o   (count)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign emit       = !out_valid_q || !out_stall_i;
  assign scan_end   = (idx_q == count);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    pos_found_d = pos_found_q;
    used_d      = used_q;
    cand_d      = cand_q;
    cnt_d       = cnt_q;
    res_kind_d  = res_kind_q;
    res_id_d    = res_id_q;
    res_ok_d    = res_ok_q;
    per_d       = per_q;
    newdl_d     = newdl_q;
    sum_d       = sum_q;
    cmd.op      = ST_NOP;
    cmd.ent     = '{id: cand_q[ID_W-1:0], own: own_q, per: per_q, dl: newdl_q};
    cmd_idx     = idx_q[IXW-1:0];
    add_a       = now_q;
    add_b       = per_q;
    cmp_a       = rd_ent.dl;
    cmp_b       = newdl_q;
    out_load    = 1'b0;
    o_kind      = res_kind_q;
    o_id        = '0;
    o_own       = '0;
    o_ok        = 1'b0;
    o_cnt       = '0;
    o_last      = 1'b1;

    case (state_q)
      S_IDLE: begin
        idx_d    = '0;
        cnt_d    = '0;
        res_id_d = '0;
        res_ok_d = (count != '0);
        if (in_acc) begin
          case (opcode_i)
            OP_ADD: begin
              res_kind_d = K_ADD;
              state_d    = (count >= CW'(TIMER_SLOTS)) ? S_DONE : S_ADD_MUL;
            end
            OP_DEL_ID: begin
              res_kind_d = K_DEL;
              res_ok_d   = 1'b0;
              state_d    = (timer_id_i == '0) ? S_DONE : S_DEL_ID;
            end
            OP_DEL_OWN: begin
              res_kind_d = K_DEL;
              state_d    = S_DEL_OWN;
            end
            OP_DEL_ALL: begin
              res_kind_d = K_DEL;
              cmd.op     = ST_CLR;
              state_d    = S_DONE;
            end
            OP_TICK: begin
              res_kind_d = K_SUM;
              state_d    = S_TK_CHK;
            end
            default: ;
          endcase
        end
      end
      S_ADD_MUL: begin
        per_d   = PER_W'(ms_q * US_PER_MS);
        state_d = S_ADD_DL;
      end
      S_ADD_DL: begin
        newdl_d     = sum;
        used_d      = '0;
        pos_found_d = 1'b0;
        state_d     = S_ADD_SCAN;
      end
      S_ADD_SCAN: begin
        if (scan_end) begin
          if (!pos_found_q) pos_d = idx_q;
          cand_d  = CAND_W'(1);
          state_d = S_ADD_ID;
        end else begin
          used_d[rd_ent.id] = 1'b1;
          if (!pos_found_q && !lt) begin
            pos_found_d = 1'b1;
            pos_d       = idx_q;
          end
          idx_d = idx_q + 1'b1;
        end
      end
      S_ADD_ID: begin
        if (cand_q[CAND_W-1:ID_W] == '0 && used_q[cand_q[ID_W-1:0]]) begin
          cand_d = cand_q + 1'b1;
        end else begin
          state_d = S_ADD_INS;
        end
      end
      S_ADD_INS: begin
        cmd.op   = ST_INS;
        cmd_idx  = pos_q[IXW-1:0];
        res_id_d = cand_q[ID_W-1:0];
        state_d  = S_DONE;
      end
      S_DEL_ID: begin
        if (scan_end) begin
          state_d = S_DONE;
        end else if ({{(TID_W - ID_W){1'b0}}, rd_ent.id} == tid_q) begin
          cmd.op   = ST_DEL;
          res_ok_d = 1'b1;
          state_d  = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DEL_OWN: begin
        if (scan_end) begin
          state_d = S_DONE;
        end else if (rd_ent.own == own_q) begin
          cmd.op = ST_DEL;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_TK_CHK: begin
        cmp_a = now_q;
        cmp_b = rd_ent.dl;
        add_a = rd_ent.dl;
        add_b = rd_ent.per;
        if (scan_end || rd_ent.id == '0 || lt) begin
          state_d = S_DONE;
        end else begin
          sum_d   = sum;
          state_d = S_TK_FIX;
        end
      end
      S_TK_FIX: begin
        cmp_a = sum_q;
        cmp_b = now_q;
        add_a = now_q;
        add_b = rd_ent.per;
        if (emit) begin
          cmd.op     = ST_WDL;
          cmd.ent.dl = lt ? sum : sum_q;
          out_load   = 1'b1;
          o_kind     = K_FIRE;
          o_id       = rd_ent.id;
          o_own      = rd_ent.own;
          o_last     = 1'b0;
          if (rd_ent.per != '0) cnt_d = cnt_q + 1'b1;
          idx_d   = idx_q + 1'b1;
          state_d = S_TK_CHK;
        end
      end
      S_DONE: begin
        if (emit) begin
          out_load = 1'b1;
          o_id     = (res_kind_q == K_ADD) ? res_id_q : '0;
          o_ok     = (res_kind_q == K_DEL) ? res_ok_q : 1'b0;
          o_cnt    = (res_kind_q == K_SUM) ? cnt_q : '0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      pos_q       <= '0;
      pos_found_q <= 1'b0;
      cand_q      <= '0;
      cnt_q       <= '0;
      res_kind_q  <= K_ADD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      pos_found_q <= pos_found_d;
      cand_q      <= cand_d;
      cnt_q       <= cnt_d;
      res_kind_q  <= res_kind_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    used_q   <= used_d;
    res_id_q <= res_id_d;
    res_ok_q <= res_ok_d;
    per_q    <= per_d;
    newdl_q  <= newdl_d;
    sum_q    <= sum_d;
    if (in_acc) begin
      now_q <= now_us_i;
      ms_q  <= interval_ms_i;
      tid_q <= timer_id_i;
      own_q <= owner_tag_i;
    end
    if (out_load) begin
      out_kind_q <= o_kind;
      out_id_q   <= o_id;
      out_own_q  <= o_own;
      out_ok_q   <= o_ok;
      out_cnt_q  <= o_cnt;
      out_last_q <= o_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign result_id_o    = out_id_q;
  assign fired_owner_o  = out_own_q;
  assign success_o      = out_ok_q;
  assign active_count_o = out_cnt_q;
  assign last_o         = out_last_q;

endmodule

[src/ptle_alu.sv]
module ptle_alu (
  input  logic [ptle_pkg::DL_W-1:0]  add_a_i,
  input  logic [ptle_pkg::PER_W-1:0] add_b_i,
  input  logic [ptle_pkg::DL_W-1:0]  cmp_a_i,
  input  logic [ptle_pkg::DL_W-1:0]  cmp_b_i,
  output logic [ptle_pkg::DL_W-1:0]  sum_o,
  output logic                       lt_o
);
  import ptle_pkg::*;

  logic [DL_W:0] raw;

  assign raw   = {1'b0, add_a_i} + {{(DL_W + 1 - PER_W){1'b0}}, add_b_i};
  assign sum_o = raw[DL_W] ? DL_MAX : raw[DL_W-1:0];
  assign lt_o  = cmp_a_i < cmp_b_i;

endmodule

[src/ptle_store.sv]
module ptle_store #(
  parameter int unsigned TIMER_SLOTS = ptle_pkg::TIMER_SLOTS_DEF,
  parameter int unsigned IXW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1,
  parameter int unsigned CW  = $clog2(TIMER_SLOTS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptle_pkg::st_cmd_t  cmd_i,
  input  logic [IXW-1:0]     cmd_idx_i,
  input  logic [IXW-1:0]     rd_idx_i,
  output ptle_pkg::entry_t   rd_ent_o,
  output logic [CW-1:0]      count_o
);
  import ptle_pkg::*;

  entry_t        ent_q [TIMER_SLOTS];
  logic [CW-1:0] count_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ST_WDL: ent_q[cmd_idx_i].dl <= cmd_i.ent.dl;
      ST_INS: begin
        ent_q[cmd_idx_i] <= cmd_i.ent;
        for (int j = 1; j < TIMER_SLOTS; j++) begin
          if (j > cmd_idx_i) ent_q[j] <= ent_q[j-1];
        end
      end
      ST_DEL: begin
        for (int j = 0; j + 1 < TIMER_SLOTS; j++) begin
          if (j >= cmd_idx_i) ent_q[j] <= ent_q[j+1];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      case (cmd_i.op)
        ST_INS:  count_q <= count_q + 1'b1;
        ST_DEL:  count_q <= count_q - 1'b1;
        ST_CLR:  count_q <= '0;
        default: ;
      endcase
    end
  end

  assign rd_ent_o = ent_q[rd_idx_i];
  assign count_o  = count_q;

endmodule

[src/ptle_checker.sv]
module ptle_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [ptle_pkg::OP_W-1:0]    opcode_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [ptle_pkg::KIND_W-1:0]  kind_o,
  input logic [ptle_pkg::ID_W-1:0]    result_id_o,
  input logic [ptle_pkg::OWN_W-1:0]   fired_owner_o,
  input logic                         success_o,
  input logic [ptle_pkg::CNT_W-1:0]   active_count_o,
  input logic                         last_o
);
  import ptle_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(result_id_o)
      && $stable(last_o))
    else $error("result word changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && opcode_i <= OP_TICK |=> in_stall_o)
    else $error("accepted operation word did not make the block busy");

  a_fire_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == K_FIRE |-> !last_o)
    else $error("fire word flagged last");

  a_answer_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != K_FIRE |-> last_o)
    else $error("answer word not flagged last");

  a_del_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == K_DEL |-> result_id_o == '0 && fired_owner_o == '0
      && active_count_o == '0)
    else $error("delete answer carries stray fields");

endmodule

bind periodic_timer_list_engine ptle_checker u_ptle_checker (.*);
